[rtl/core/evk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package evk_pkg;

  localparam int DEN_W   = 88;
  localparam int CDEN_W  = 80;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] RPM_K   = 24'd15000000;
  localparam logic [19:0] SPEED_K = 20'd1000000;
  localparam logic [24:0] ONE24   = 25'h1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_CPR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QNOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RNOISE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET = 3'd4;

  localparam logic [15:0] CPR_RST    = 16'd8192;
  localparam logic [23:0] CIRC_RST   = 24'd5149257;
  localparam logic [23:0] QNOISE_RST = 24'd1678;
  localparam logic [23:0] RNOISE_RST = 24'd3355443;
  localparam logic [15:0] PRESET_RST = 16'd600;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_TURN,
    OP_TURN_FIN,
    OP_PRESET,
    OP_MUL_RPM,
    OP_MUL_DEN_LO,
    OP_MUL_DEN_HI,
    OP_DIV_RPM,
    OP_RPM_FIN,
    OP_MUL_MC,
    OP_DIV_STEP,
    OP_POS_UPD,
    OP_MUL_SN_LO,
    OP_MUL_SN_HI,
    OP_DIV_SPEED,
    OP_SPEED_FIN,
    OP_KAL_PREP,
    OP_DIV_GAIN,
    OP_GAIN_FIN,
    OP_MUL_VAR,
    OP_MUL_EST_LO,
    OP_MUL_EST_HI,
    OP_EST_FIN,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic preset;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/evk_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface evk_in_if #(parameter int CNT_W = 16);
  logic             valid;
  logic             ready;
  logic             func;
  logic [CNT_W-1:0] counter_value;
  logic [63:0]      timestamp_us;

  modport source(output valid, output func, output counter_value, output timestamp_us,
                 input ready);
  modport sink(input valid, input func, input counter_value, input timestamp_us,
               output ready);
endinterface

interface evk_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        turn_position;
  logic signed [31:0] angular_rpm;
  logic signed [47:0] linear_position_mm;
  logic signed [31:0] linear_speed_mm_s;
  logic signed [23:0] filtered_speed_mm_s;
  logic               zero_interval;

  modport source(output valid, output turn_position, output angular_rpm,
                 output linear_position_mm, output linear_speed_mm_s,
                 output filtered_speed_mm_s, output zero_interval, input ready);
  modport sink(input valid, input turn_position, input angular_rpm,
               input linear_position_mm, input linear_speed_mm_s,
               input filtered_speed_mm_s, input zero_interval, output ready);
endinterface

interface evk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/evk_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module evk_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 88,
  parameter int IT_W  = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [IT_W-1:0]  iters,
  output logic             busy,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  logic             busy_r;
  logic [IT_W-1:0]  cnt_r;
  logic [NUM_W-1:0] nq_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_s;
  logic [DEN_W:0]   rem_d;
  logic             ge;

  assign rem_s = {rem_r, nq_r[NUM_W-1]};
  assign rem_d = rem_s - {1'b0, den_r};
  assign ge    = rem_s >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == IT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num << (IT_W'(NUM_W) - iters);
      rem_r <= DEN_W'(num >> iters);
      den_r <= den;
    end else if (busy_r) begin
      nq_r  <= {nq_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_d[DEN_W-1:0] : rem_s[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = nq_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[rtl/core/evk_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module evk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  evk_pkg::dp_status_t status,
  output evk_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [28:0] {
    ST_IDLE     = 29'd1 << 0,
    ST_TURN     = 29'd1 << 1,
    ST_TURN_W   = 29'd1 << 2,
    ST_TURN_FIN = 29'd1 << 3,
    ST_PRESET   = 29'd1 << 4,
    ST_MUL_RPM  = 29'd1 << 5,
    ST_DEN_LO   = 29'd1 << 6,
    ST_DEN_HI   = 29'd1 << 7,
    ST_RPM      = 29'd1 << 8,
    ST_RPM_W    = 29'd1 << 9,
    ST_RPM_FIN  = 29'd1 << 10,
    ST_MC       = 29'd1 << 11,
    ST_STEP     = 29'd1 << 12,
    ST_STEP_W   = 29'd1 << 13,
    ST_POS      = 29'd1 << 14,
    ST_SN_LO    = 29'd1 << 15,
    ST_SN_HI    = 29'd1 << 16,
    ST_SPD      = 29'd1 << 17,
    ST_SPD_W    = 29'd1 << 18,
    ST_SPD_FIN  = 29'd1 << 19,
    ST_KPREP    = 29'd1 << 20,
    ST_GAIN     = 29'd1 << 21,
    ST_GAIN_W   = 29'd1 << 22,
    ST_GAIN_FIN = 29'd1 << 23,
    ST_VAR      = 29'd1 << 24,
    ST_EST_LO   = 29'd1 << 25,
    ST_EST_HI   = 29'd1 << 26,
    ST_EST_FIN  = 29'd1 << 27,
    ST_OUT      = 29'd1 << 28
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = evk_pkg::OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = evk_pkg::OP_LOAD;
          state_nxt = ST_TURN;
        end
      end
      ST_TURN: begin
        cmd.op    = evk_pkg::OP_DIV_TURN;
        state_nxt = ST_TURN_W;
      end
      ST_TURN_W: if (!status.div_busy) state_nxt = ST_TURN_FIN;
      ST_TURN_FIN: begin
        cmd.op    = evk_pkg::OP_TURN_FIN;
        state_nxt = status.preset ? ST_PRESET : ST_MUL_RPM;
      end
      ST_PRESET: begin
        cmd.op    = evk_pkg::OP_PRESET;
        state_nxt = ST_OUT;
      end
      ST_MUL_RPM: begin
        cmd.op    = evk_pkg::OP_MUL_RPM;
        state_nxt = ST_DEN_LO;
      end
      ST_DEN_LO: begin
        cmd.op    = evk_pkg::OP_MUL_DEN_LO;
        state_nxt = ST_DEN_HI;
      end
      ST_DEN_HI: begin
        cmd.op    = evk_pkg::OP_MUL_DEN_HI;
        state_nxt = ST_RPM;
      end
      ST_RPM: begin
        cmd.op    = evk_pkg::OP_DIV_RPM;
        state_nxt = ST_RPM_W;
      end
      ST_RPM_W: if (!status.div_busy) state_nxt = ST_RPM_FIN;
      ST_RPM_FIN: begin
        cmd.op    = evk_pkg::OP_RPM_FIN;
        state_nxt = ST_MC;
      end
      ST_MC: begin
        cmd.op    = evk_pkg::OP_MUL_MC;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.op    = evk_pkg::OP_DIV_STEP;
        state_nxt = ST_STEP_W;
      end
      ST_STEP_W: if (!status.div_busy) state_nxt = ST_POS;
      ST_POS: begin
        cmd.op    = evk_pkg::OP_POS_UPD;
        state_nxt = ST_SN_LO;
      end
      ST_SN_LO: begin
        cmd.op    = evk_pkg::OP_MUL_SN_LO;
        state_nxt = ST_SN_HI;
      end
      ST_SN_HI: begin
        cmd.op    = evk_pkg::OP_MUL_SN_HI;
        state_nxt = ST_SPD;
      end
      ST_SPD: begin
        cmd.op    = evk_pkg::OP_DIV_SPEED;
        state_nxt = ST_SPD_W;
      end
      ST_SPD_W: if (!status.div_busy) state_nxt = ST_SPD_FIN;
      ST_SPD_FIN: begin
        cmd.op    = evk_pkg::OP_SPEED_FIN;
        state_nxt = ST_KPREP;
      end
      ST_KPREP: begin
        cmd.op    = evk_pkg::OP_KAL_PREP;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.op    = evk_pkg::OP_DIV_GAIN;
        state_nxt = ST_GAIN_W;
      end
      ST_GAIN_W: if (!status.div_busy) state_nxt = ST_GAIN_FIN;
      ST_GAIN_FIN: begin
        cmd.op    = evk_pkg::OP_GAIN_FIN;
        state_nxt = ST_VAR;
      end
      ST_VAR: begin
        cmd.op    = evk_pkg::OP_MUL_VAR;
        state_nxt = ST_EST_LO;
      end
      ST_EST_LO: begin
        cmd.op    = evk_pkg::OP_MUL_EST_LO;
        state_nxt = ST_EST_HI;
      end
      ST_EST_HI: begin
        cmd.op    = evk_pkg::OP_MUL_EST_HI;
        state_nxt = ST_EST_FIN;
      end
      ST_EST_FIN: begin
        cmd.op    = evk_pkg::OP_EST_FIN;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.op    = evk_pkg::OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/evk_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module evk_dp #(
  parameter int CB = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  evk_pkg::ctrl_cmd_t  cmd,
  output evk_pkg::dp_status_t status,
  input  logic                in_func,
  input  logic [CB-1:0]       in_count,
  input  logic [63:0]         in_time,
  input  logic                cfg_we,
  input  logic [evk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evk_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_turn,
  output logic [31:0]         out_rpm,
  output logic [47:0]         out_pos,
  output logic [31:0]         out_speed,
  output logic [23:0]         out_filt,
  output logic                out_zero
);

  localparam int MC_W  = CB + 24;
  localparam int RN_W  = CB + 34;
  localparam int NUM_W = CB + 44;
  localparam int DEN_W = evk_pkg::DEN_W;
  localparam int CD_W  = evk_pkg::CDEN_W;
  localparam int IT_W  = $clog2(NUM_W + 1);

  logic [15:0] cpr_r;
  logic [23:0] circ_r, qn_r, rn_r;
  logic [15:0] preset_r;

  logic [CB-1:0] prev_cnt_r;
  logic [63:0]   prev_time_r;
  logic [47:0]   pos_r;
  logic [47:0]   est_r;
  logic [24:0]   var_r;

  logic            func_r, neg_r, sat_r, dneg_r;
  logic [CB-1:0]   mag_r;
  logic [63:0]     dt_r;
  logic [RN_W-1:0] rnum_r;
  logic [CD_W-1:0] cden_r;
  logic [MC_W-1:0] mc_r;
  logic [NUM_W-1:0] snum_r;
  logic [15:0]     turn_r;
  logic [31:0]     rpm_r, spd_mag_r, spd_r;
  logic [25:0]     ppred_r;
  logic [26:0]     kden_r;
  logic [24:0]     gain_r;
  logic [48:0]     dmag_r;
  logic [73:0]     w_r;
  logic            out_valid_r;

  logic [15:0]      cpr_eff;
  logic             div_start;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den, div_rem;
  logic [IT_W-1:0]  div_iters;
  logic             div_busy;
  logic [63:0]      mc64;
  logic [CB-1:0]    raw;
  logic [31:0]      q_mag;
  logic [25:0]      ppred;
  logic [48:0]      zq, diff;
  logic [47:0]      kstep, est_mag;
  logic [23:0]      filt;

  function automatic logic [31:0] sat_mag(input logic [31:0] q, input logic sat,
                                          input logic neg);
    logic [31:0] cap;
    cap = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return (sat || (q > cap)) ? cap : q;
  endfunction

  assign cpr_eff = (cpr_r == 16'd0) ? 16'd1 : cpr_r;
  assign mc64    = 64'(mc_r);
  assign raw     = in_count - prev_cnt_r;
  assign q_mag   = sat_mag(div_quo[31:0], sat_r, neg_r);
  assign ppred   = 26'(var_r) + 26'(qn_r);
  assign zq      = neg_r ? (49'd0 - {1'b0, spd_mag_r[31:8], 24'd0})
                         : {1'b0, spd_mag_r[31:8], 24'd0};
  assign diff    = zq - {est_r[47], est_r};
  assign kstep   = w_r[71:24];
  assign est_mag = 48'd0 - est_r;
  assign filt    = est_r[47] ? (24'd0 - est_mag[47:24]) : est_r[47:24];

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iters = '0;
    case (cmd.op)
      evk_pkg::OP_DIV_TURN: begin
        div_start = 1'b1;
        div_num   = NUM_W'(prev_cnt_r);
        div_den   = DEN_W'(cpr_eff);
        div_iters = IT_W'(CB);
      end
      evk_pkg::OP_DIV_RPM: begin
        div_start = 1'b1;
        div_num   = NUM_W'(rnum_r);
        div_den   = DEN_W'(cden_r);
        div_iters = IT_W'(32);
      end
      evk_pkg::OP_DIV_STEP: begin
        div_start = 1'b1;
        div_num   = NUM_W'(mc_r);
        div_den   = DEN_W'(cpr_eff);
        div_iters = IT_W'(MC_W);
      end
      evk_pkg::OP_DIV_SPEED: begin
        div_start = 1'b1;
        div_num   = snum_r;
        div_den   = {cden_r, 8'd0};
        div_iters = IT_W'(32);
      end
      evk_pkg::OP_DIV_GAIN: begin
        div_start = 1'b1;
        div_num   = NUM_W'({ppred_r, 24'd0});
        div_den   = DEN_W'(kden_r);
        div_iters = IT_W'(25);
      end
      default: div_start = 1'b0;
    endcase
  end

  evk_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W),
    .IT_W (IT_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .iters(div_iters),
    .busy (div_busy),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r    <= evk_pkg::CPR_RST;
      circ_r   <= evk_pkg::CIRC_RST;
      qn_r     <= evk_pkg::QNOISE_RST;
      rn_r     <= evk_pkg::RNOISE_RST;
      preset_r <= evk_pkg::PRESET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        evk_pkg::CFG_CPR:    cpr_r    <= cfg_data[15:0];
        evk_pkg::CFG_CIRC:   circ_r   <= cfg_data;
        evk_pkg::CFG_QNOISE: qn_r     <= cfg_data;
        evk_pkg::CFG_RNOISE: rn_r     <= cfg_data;
        evk_pkg::CFG_PRESET: preset_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cnt_r  <= '0;
      prev_time_r <= '0;
      pos_r       <= '0;
      est_r       <= '0;
      var_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == evk_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        evk_pkg::OP_LOAD: begin
          if (!in_func) begin
            prev_cnt_r  <= in_count;
            prev_time_r <= in_time;
          end
        end
        evk_pkg::OP_PRESET: pos_r <= {{16{preset_r[15]}}, preset_r, 16'd0};
        evk_pkg::OP_POS_UPD: begin
          pos_r <= neg_r ? (pos_r - div_quo[47:0]) : (pos_r + div_quo[47:0]);
        end
        evk_pkg::OP_MUL_VAR: var_r <= 25'((51'(ppred_r) * 51'(evk_pkg::ONE24 - gain_r)) >> 24);
        evk_pkg::OP_EST_FIN: est_r <= dneg_r ? (est_r - kstep) : (est_r + kstep);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      evk_pkg::OP_LOAD: begin
        func_r <= in_func;
        neg_r  <= raw[CB-1];
        mag_r  <= raw[CB-1] ? (CB'(0) - raw) : raw;
        dt_r   <= in_time - prev_time_r;
      end
      evk_pkg::OP_TURN_FIN:   turn_r <= div_rem[15:0];
      evk_pkg::OP_MUL_RPM: begin
        rnum_r <= {MC_W'(mag_r) * MC_W'(evk_pkg::RPM_K), 10'd0};
      end
      evk_pkg::OP_MUL_DEN_LO: cden_r <= CD_W'(48'(cpr_eff) * 48'(dt_r[31:0]));
      evk_pkg::OP_MUL_DEN_HI: begin
        cden_r <= cden_r + {48'(cpr_eff) * 48'(dt_r[63:32]), 32'd0};
      end
      evk_pkg::OP_DIV_RPM:    sat_r <= DEN_W'(div_num >> 32) >= div_den;
      evk_pkg::OP_RPM_FIN: begin
        if (rnum_r == '0) begin
          rpm_r <= 32'd0;
        end else begin
          rpm_r <= neg_r ? (32'd0 - q_mag) : q_mag;
        end
      end
      evk_pkg::OP_MUL_MC:     mc_r <= MC_W'(mag_r) * MC_W'(circ_r);
      evk_pkg::OP_MUL_SN_LO:  snum_r <= NUM_W'(52'(mc64[31:0]) * 52'(evk_pkg::SPEED_K));
      evk_pkg::OP_MUL_SN_HI: begin
        snum_r <= snum_r + NUM_W'({52'(mc64[63:32]) * 52'(evk_pkg::SPEED_K), 32'd0});
      end
      evk_pkg::OP_DIV_SPEED:  sat_r <= DEN_W'(div_num >> 32) >= div_den;
      evk_pkg::OP_SPEED_FIN: begin
        if (snum_r == '0) begin
          spd_mag_r <= 32'd0;
          spd_r     <= 32'd0;
        end else begin
          spd_mag_r <= q_mag;
          spd_r     <= neg_r ? (32'd0 - q_mag) : q_mag;
        end
      end
      evk_pkg::OP_KAL_PREP: begin
        ppred_r <= ppred;
        kden_r  <= 27'(ppred) + 27'(rn_r);
        dneg_r  <= diff[48];
        dmag_r  <= diff[48] ? (49'd0 - diff) : diff;
      end
      evk_pkg::OP_GAIN_FIN:   gain_r <= (kden_r == 27'd0) ? 25'd0 : div_quo[24:0];
      evk_pkg::OP_MUL_EST_LO: w_r <= 74'(57'(dmag_r[31:0]) * 57'(gain_r));
      evk_pkg::OP_MUL_EST_HI: w_r <= w_r + {42'(dmag_r[48:32]) * 42'(gain_r), 32'd0};
      evk_pkg::OP_OUT: begin
        out_turn  <= turn_r;
        out_rpm   <= func_r ? 32'd0 : rpm_r;
        out_pos   <= pos_r;
        out_speed <= func_r ? 32'd0 : spd_r;
        out_filt  <= filt;
        out_zero  <= !func_r && (dt_r == 64'd0);
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign status.div_busy = div_busy;
  assign status.preset   = func_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

[rtl/core/encoder_velocity_kalman_top.sv]
// Quadrature encoder velocity estimator with scalar Kalman smoothing.
// in_ch carries one item per transfer: func (0 sample, 1 load position
// preset), the raw counter reading and a microsecond timestamp. Each item
// gives exactly one result on out_ch: turn position, rpm (Q24.8), linear
// position (Q32.16), linear speed (Q24.8), filtered speed and the
// zero-interval flag. cfg_ch writes the five registers by index; it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. One item is worked at a time, and
// the next item can be taken in the cycle after the result is registered.
// One shared divider, one quotient bit per cycle, runs five times per
// sample (turn modulo, rpm, position step, speed, gain). A stalled
// receiver holds the result in the output register; the block takes one
// more item meanwhile and waits with its result until the slot frees.
// Reset (rst_n low, synchronous) loads register defaults and clears all
// filter and history state and any pending result.
`timescale 1ns / 1ps
`default_nettype none

module encoder_velocity_kalman_top #(
  parameter int COUNTER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  evk_in_if.sink     in_ch,
  evk_out_if.source  out_ch,
  evk_cfg_if.sink    cfg_ch
);

  evk_pkg::ctrl_cmd_t  cmd;
  evk_pkg::dp_status_t status;
  logic                in_ready;
  logic [31:0]         out_rpm, out_speed;
  logic [47:0]         out_pos;
  logic [23:0]         out_filt;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  evk_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  evk_dp #(
    .CB(COUNTER_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_func  (in_ch.func),
    .in_count (in_ch.counter_value),
    .in_time  (in_ch.timestamp_us),
    .cfg_we   (cfg_ch.valid),
    .cfg_index(cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_turn (out_ch.turn_position),
    .out_rpm  (out_rpm),
    .out_pos  (out_pos),
    .out_speed(out_speed),
    .out_filt (out_filt),
    .out_zero (out_ch.zero_interval)
  );

  assign out_ch.angular_rpm         = $signed(out_rpm);
  assign out_ch.linear_position_mm  = $signed(out_pos);
  assign out_ch.linear_speed_mm_s   = $signed(out_speed);
  assign out_ch.filtered_speed_mm_s = $signed(out_filt);

endmodule

`default_nettype wire
